FILE: rtl/imq_pkg.sv
// Shared constants, register map and a helper function for the IMU motion quality conditioner.
package imq_pkg;

	localparam int unsigned SampleW  = 16;
	localparam int unsigned NormW    = 13;
	localparam int unsigned EnergyW  = 14;
	localparam int unsigned GradeW   = 7;
	localparam int unsigned LimitW   = 15;
	localparam int unsigned AddrW    = 5;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned InDataW  = 96;
	localparam int unsigned OutDataW = 144;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] RegGyroThr    = 3'd0;
	localparam logic [2:0] RegNormMargin = 3'd1;
	localparam logic [2:0] RegAccelZBias = 3'd2;
	localparam logic [2:0] RegGyroXBias  = 3'd3;
	localparam logic [2:0] RegGyroYBias  = 3'd4;
	localparam logic [2:0] RegGyroZBias  = 3'd5;
	localparam logic [2:0] RegCalibrated = 3'd6;
	localparam logic [2:0] RegPending    = 3'd7;

	// counts to milli-g: * 1000 >> 14
	localparam logic [9:0]  MgPerG     = 10'd1000;
	localparam logic [12:0] OneGMg     = 13'd1000;

	// floor(x / 3) = (x * Recip3) >> 17 for x < 2^17
	localparam logic [15:0] Recip3     = 16'd43691;
	// floor(x / 5) = (x * Recip5) >> 19 for x < 2^18
	localparam logic [16:0] Recip5     = 17'd104858;

	localparam logic [12:0] DevLimitMoving = 13'd240;
	localparam logic [12:0] DevLimit       = 13'd320;
	localparam logic [12:0] ScoreQuiet     = 13'd25;

	localparam logic [6:0] GradeUncal   = 7'd35;
	localparam logic [6:0] GradePending = 7'd55;
	localparam logic [6:0] GradeMoving  = 7'd60;
	localparam logic [6:0] GradeDrift   = 7'd45;
	localparam logic [6:0] GradeQuiet   = 7'd85;
	localparam logic [6:0] GradeBest    = 7'd100;

	// magnitude of a two's complement sample; the most negative value gives 32768
	function automatic logic [15:0] mag16(input logic [15:0] v);
		return v[15] ? (~v + 16'd1) : v;
	endfunction

endpackage

FILE: rtl/imu_motion_quality_conditioner.sv
// IMU motion quality conditioner: norm filter, stillness, bias removal and grading.
// A sample accepted into the stage 1 register passes stages 2, 3 and 4 to the output register, which drives m_tvalid.
// Throughput: one sample per cycle; a five-register pipeline with per-stage enables
// lets s_tready stay high while any stage is empty or the output is being taken.
// The smoothed-norm and baseline recurrences close through their own state registers within the middle stage.
// Reset (arst_n low) clears all valid bits, the filter state and the config registers.
module imu_motion_quality_conditioner (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, lowest first)
	input  logic [imq_pkg::InDataW-1:0]       s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// accel_z_corrected[15:0], rate_x_corrected[31:16], rate_y_corrected[47:32],
	// rate_z_corrected[63:48], still_flag[64], smoothed_norm_mg[77:65],
	// baseline_norm_mg[90:78], norm_deviation_mg[103:91], rotation_energy[117:104],
	// activity_score[130:118], quality_grade[137:131], zero pad[143:138]
	output logic [imq_pkg::OutDataW-1:0]      m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [imq_pkg::AddrW-1:0]         paddr,
	input  logic [imq_pkg::ApbDataW-1:0]      pwdata,
	output logic [imq_pkg::ApbDataW-1:0]      prdata,
	output logic                              pready
);

	// configuration registers
	logic [imq_pkg::LimitW-1:0]  gyro_thr_q;
	logic [imq_pkg::LimitW-1:0]  norm_margin_q;
	logic [15:0]                 az_bias_q;
	logic [15:0]                 gx_bias_q;
	logic [15:0]                 gy_bias_q;
	logic [15:0]                 gz_bias_q;
	logic                        calibrated_q;
	logic                        pending_q;
	logic                        cfg_wr;

	// filter state
	logic [imq_pkg::NormW-1:0]   smoothed_q;
	logic [imq_pkg::NormW-1:0]   baseline_q;

	// stage enables
	logic en1, en2, en3, en4, en_o;
	logic v_s1, v_s2, v_s3, v_s4, vo_q;

	// stage 1: input register
	logic [15:0] ax_s1, ay_s1, az_s1, gx_s1, gy_s1, gz_s1;

	// stage A logic
	logic [16:0] mag_sum_a;
	logic [26:0] norm_prod_a;
	logic        gyro_ok_a;
	logic [15:0] cz_a, cx_a, cy_a, crz_a;
	logic [16:0] esum_a;

	// stage 2
	logic [imq_pkg::NormW-1:0] norm_s2;
	logic                      gyro_ok_s2;
	logic [15:0]               cz_s2, cx_s2, cy_s2, crz_s2;
	logic [16:0]               esum_s2;

	// stage B logic
	logic [14:0]               smooth_sum_b;
	logic [imq_pkg::NormW-1:0] smooth_b;
	logic [imq_pkg::NormW-1:0] off_b;
	logic                      still_b;
	logic [15:0]               base_sum_b;
	logic [imq_pkg::NormW-1:0] base_next_b;
	logic [30:0]               energy_prod_b;

	// stage 3
	logic [imq_pkg::NormW-1:0]   smooth_s3, base_s3;
	logic                        still_s3;
	logic [imq_pkg::EnergyW-1:0] energy_s3;
	logic [15:0]                 cz_s3, cx_s3, cy_s3, crz_s3;

	// stage C logic
	logic [imq_pkg::NormW-1:0] dev_c;
	logic [15:0]               ssum_c;

	// stage 4
	logic [imq_pkg::NormW-1:0]   smooth_s4, base_s4, dev_s4;
	logic                        still_s4;
	logic [imq_pkg::EnergyW-1:0] energy_s4;
	logic [15:0]                 ssum_s4;
	logic [15:0]                 cz_s4, cx_s4, cy_s4, crz_s4;

	// stage D logic
	logic [32:0]               score_prod_d;
	logic [imq_pkg::NormW-1:0] score_d;
	logic [imq_pkg::GradeW-1:0] grade_d;

	// output register
	logic [15:0]                 cz_q, cx_q, cy_q, crz_q;
	logic                        still_q;
	logic [imq_pkg::NormW-1:0]   smooth_q, base_q, dev_q, score_q;
	logic [imq_pkg::EnergyW-1:0] energy_q;
	logic [imq_pkg::GradeW-1:0]  grade_q;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_thr_q    <= '0;
			norm_margin_q <= '0;
			az_bias_q     <= '0;
			gx_bias_q     <= '0;
			gy_bias_q     <= '0;
			gz_bias_q     <= '0;
			calibrated_q  <= 1'b0;
			pending_q     <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				imq_pkg::RegGyroThr:    gyro_thr_q    <= pwdata[imq_pkg::LimitW-1:0];
				imq_pkg::RegNormMargin: norm_margin_q <= pwdata[imq_pkg::LimitW-1:0];
				imq_pkg::RegAccelZBias: az_bias_q     <= pwdata[15:0];
				imq_pkg::RegGyroXBias:  gx_bias_q     <= pwdata[15:0];
				imq_pkg::RegGyroYBias:  gy_bias_q     <= pwdata[15:0];
				imq_pkg::RegGyroZBias:  gz_bias_q     <= pwdata[15:0];
				imq_pkg::RegCalibrated: calibrated_q  <= pwdata[0];
				imq_pkg::RegPending:    pending_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			imq_pkg::RegGyroThr:    prdata = {17'd0, gyro_thr_q};
			imq_pkg::RegNormMargin: prdata = {17'd0, norm_margin_q};
			imq_pkg::RegAccelZBias: prdata = {{16{az_bias_q[15]}}, az_bias_q};
			imq_pkg::RegGyroXBias:  prdata = {{16{gx_bias_q[15]}}, gx_bias_q};
			imq_pkg::RegGyroYBias:  prdata = {{16{gy_bias_q[15]}}, gy_bias_q};
			imq_pkg::RegGyroZBias:  prdata = {{16{gz_bias_q[15]}}, gz_bias_q};
			imq_pkg::RegCalibrated: prdata = {31'd0, calibrated_q};
			imq_pkg::RegPending:    prdata = {31'd0, pending_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// a stage loads when it is empty or its content moves on
	assign en_o     = !vo_q || m_tready;
	assign en4      = !v_s4 || en_o;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1)  v_s1 <= s_tvalid;
			if (en2)  v_s2 <= v_s1;
			if (en3)  v_s3 <= v_s2;
			if (en4)  v_s4 <= v_s3;
			if (en_o) vo_q <= v_s4;
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= s_tdata[15:0];
			ay_s1 <= s_tdata[31:16];
			az_s1 <= s_tdata[47:32];
			gx_s1 <= s_tdata[63:48];
			gy_s1 <= s_tdata[79:64];
			gz_s1 <= s_tdata[95:80];
		end
	end

	// ---------------------------------------------------------------- stage A
	always_comb begin
		mag_sum_a   = 17'(imq_pkg::mag16(ax_s1)) + 17'(imq_pkg::mag16(ay_s1))
		            + 17'(imq_pkg::mag16(az_s1));
		norm_prod_a = 27'(mag_sum_a) * 27'(imq_pkg::MgPerG);
		gyro_ok_a   = (imq_pkg::mag16(gx_s1) < {1'b0, gyro_thr_q})
		           && (imq_pkg::mag16(gy_s1) < {1'b0, gyro_thr_q})
		           && (imq_pkg::mag16(gz_s1) < {1'b0, gyro_thr_q});
		// wrap to 16 bits
		cz_a        = az_s1 - az_bias_q;
		cx_a        = gx_s1 - gx_bias_q;
		cy_a        = gy_s1 - gy_bias_q;
		crz_a       = gz_s1 - gz_bias_q;
		esum_a      = 17'(imq_pkg::mag16(cx_a)) + 17'(imq_pkg::mag16(cy_a))
		            + 17'(imq_pkg::mag16(crz_a));
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			norm_s2    <= norm_prod_a[26:14];
			gyro_ok_s2 <= gyro_ok_a;
			cz_s2      <= cz_a;
			cx_s2      <= cx_a;
			cy_s2      <= cy_a;
			crz_s2     <= crz_a;
			esum_s2    <= esum_a;
		end
	end

	// ---------------------------------------------------------------- stage B
	always_comb begin
		smooth_sum_b  = {2'b0, smoothed_q} + {1'b0, smoothed_q, 1'b0} + {2'b0, norm_s2};
		smooth_b      = smooth_sum_b[14:2];
		off_b         = (smooth_b >= imq_pkg::OneGMg) ? (smooth_b - imq_pkg::OneGMg)
		                                               : (imq_pkg::OneGMg - smooth_b);
		still_b       = gyro_ok_s2 && ({2'b0, off_b} < norm_margin_q);
		base_sum_b    = {baseline_q, 3'b0} - {3'b0, baseline_q} + {3'b0, smooth_b};
		base_next_b   = still_b ? base_sum_b[15:3] : baseline_q;
		// energy = (sum >> 2) / 3
		energy_prod_b = 31'(esum_s2[16:2]) * 31'(imq_pkg::Recip3);
	end

	// advance the recurrences once per sample leaving stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			baseline_q <= '0;
		end else if (en3 && v_s2) begin
			smoothed_q <= smooth_b;
			baseline_q <= base_next_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			smooth_s3 <= smooth_b;
			base_s3   <= base_next_b;
			still_s3  <= still_b;
			energy_s3 <= energy_prod_b[30:17];
			cz_s3     <= cz_s2;
			cx_s3     <= cx_s2;
			cy_s3     <= cy_s2;
			crz_s3    <= crz_s2;
		end
	end

	// ---------------------------------------------------------------- stage C
	always_comb begin
		dev_c  = (smooth_s3 >= base_s3) ? (smooth_s3 - base_s3) : (base_s3 - smooth_s3);
		ssum_c = {3'b0, dev_c} + {2'b0, dev_c, 1'b0} + {1'b0, energy_s3, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			smooth_s4 <= smooth_s3;
			base_s4   <= base_s3;
			dev_s4    <= dev_c;
			still_s4  <= still_s3;
			energy_s4 <= energy_s3;
			ssum_s4   <= ssum_c;
			cz_s4     <= cz_s3;
			cx_s4     <= cx_s3;
			cy_s4     <= cy_s3;
			crz_s4    <= crz_s3;
		end
	end

	// ---------------------------------------------------------------- stage D
	always_comb begin
		score_prod_d = 33'(ssum_s4) * 33'(imq_pkg::Recip5);
		score_d      = score_prod_d[31:19];
		if (!calibrated_q)
			grade_d = imq_pkg::GradeUncal;
		else if (pending_q)
			grade_d = imq_pkg::GradePending;
		else if (!still_s4 && (dev_s4 > imq_pkg::DevLimitMoving))
			grade_d = imq_pkg::GradeMoving;
		else if (dev_s4 > imq_pkg::DevLimit)
			grade_d = imq_pkg::GradeDrift;
		else if (score_d < imq_pkg::ScoreQuiet)
			grade_d = imq_pkg::GradeQuiet;
		else
			grade_d = imq_pkg::GradeBest;
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			cz_q     <= cz_s4;
			cx_q     <= cx_s4;
			cy_q     <= cy_s4;
			crz_q    <= crz_s4;
			still_q  <= still_s4;
			smooth_q <= smooth_s4;
			base_q   <= base_s4;
			dev_q    <= dev_s4;
			energy_q <= energy_s4;
			score_q  <= score_d;
			grade_q  <= grade_d;
		end
	end

	assign m_tdata = {6'd0, grade_q, score_q, energy_q, dev_q, base_q, smooth_q, still_q,
	                  crz_q, cy_q, cx_q, cz_q};

	// ---------------------------------------------------------------- assertions
	a_empty_input_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_moving_grade_not_still: assert property (@(posedge clk) disable iff (!arst_n)
		(vo_q && (grade_q == imq_pkg::GradeMoving)) |-> !still_q)
		else $error("moving grade reported for a still sample");

	a_deviation_matches: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> (dev_q == ((smooth_q >= base_q) ? (smooth_q - base_q)
		                                          : (base_q - smooth_q))))
		else $error("deviation disagrees with smoothed norm and baseline");

	a_still_needs_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && still_s3) |-> ((gyro_thr_q != '0) && (norm_margin_q != '0)))
		else $error("stillness flagged with a zero threshold or margin");

	a_state_tracks_stage3: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2) |=> (smoothed_q == smooth_s3) && (baseline_q == base_s3))
		else $error("filter state out of step with the pipeline");

endmodule

FILE: test/imu_motion_quality_conditioner_tb.sv
// Self-checking testbench for the IMU motion quality conditioner stream and register port.
module imu_motion_quality_conditioner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned DrainCycles = 8;

	// raw six-axis sample, lowest field last in the packed order
	typedef struct packed {
		logic [15:0] rate_z;
		logic [15:0] rate_y;
		logic [15:0] rate_x;
		logic [15:0] accel_z;
		logic [15:0] accel_y;
		logic [15:0] accel_x;
	} sample_t;

	typedef struct packed {
		logic [5:0]  pad;
		logic [6:0]  quality_grade;
		logic [12:0] activity_score;
		logic [13:0] rotation_energy;
		logic [12:0] norm_deviation_mg;
		logic [12:0] baseline_norm_mg;
		logic [12:0] smoothed_norm_mg;
		logic        still_flag;
		logic [15:0] rate_z_corrected;
		logic [15:0] rate_y_corrected;
		logic [15:0] rate_x_corrected;
		logic [15:0] accel_z_corrected;
	} conditioned_t;

	class quality_scoreboard;
		logic [14:0] rate_limit;
		logic [14:0] norm_margin;
		logic [15:0] bias_accel_z;
		logic [15:0] bias_rate_x;
		logic [15:0] bias_rate_y;
		logic [15:0] bias_rate_z;
		logic        calibrated;
		logic        pending;
		int unsigned smoothed_mg;
		int unsigned rest_norm_mg;
		conditioned_t expected_results[$];
		int unsigned mismatches;

		function new();
			rate_limit = '0;
			norm_margin = '0;
			bias_accel_z = '0;
			bias_rate_x = '0;
			bias_rate_y = '0;
			bias_rate_z = '0;
			calibrated = 1'b0;
			pending = 1'b0;
			smoothed_mg = 0;
			rest_norm_mg = 0;
			mismatches = 0;
		endfunction

		function int unsigned magnitude(logic [15:0] v);
			return v[15] ? 32'(65536 - int'(v)) : 32'(v);
		endfunction

		function void configure(logic [2:0] idx, logic [31:0] v);
			case (idx)
				imq_pkg::RegGyroThr:    rate_limit = v[14:0];
				imq_pkg::RegNormMargin: norm_margin = v[14:0];
				imq_pkg::RegAccelZBias: bias_accel_z = v[15:0];
				imq_pkg::RegGyroXBias:  bias_rate_x = v[15:0];
				imq_pkg::RegGyroYBias:  bias_rate_y = v[15:0];
				imq_pkg::RegGyroZBias:  bias_rate_z = v[15:0];
				imq_pkg::RegCalibrated: calibrated = v[0];
				imq_pkg::RegPending:    pending = v[0];
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			conditioned_t r;
			int unsigned norm_mg, off_mg, dev, energy, score;
			logic still;
			norm_mg = (magnitude(s.accel_x) + magnitude(s.accel_y) + magnitude(s.accel_z))
				* 1000 / 16384;
			smoothed_mg = (smoothed_mg * 3 + norm_mg) / 4;
			off_mg = smoothed_mg >= 1000 ? smoothed_mg - 1000 : 1000 - smoothed_mg;
			still = magnitude(s.rate_x) < rate_limit && magnitude(s.rate_y) < rate_limit &&
				magnitude(s.rate_z) < rate_limit && off_mg < norm_margin;
			r = '0;
			r.accel_z_corrected = s.accel_z - bias_accel_z;
			r.rate_x_corrected = s.rate_x - bias_rate_x;
			r.rate_y_corrected = s.rate_y - bias_rate_y;
			r.rate_z_corrected = s.rate_z - bias_rate_z;
			// baseline follows the smoothed norm only while at rest
			if (still) begin
				rest_norm_mg = (rest_norm_mg * 7 + smoothed_mg) / 8;
			end
			dev = smoothed_mg >= rest_norm_mg ? smoothed_mg - rest_norm_mg
				: rest_norm_mg - smoothed_mg;
			energy = (magnitude(r.rate_x_corrected) + magnitude(r.rate_y_corrected) +
				magnitude(r.rate_z_corrected)) / 12;
			score = (dev * 3 + energy * 2) / 5;
			r.still_flag = still;
			r.smoothed_norm_mg = 13'(smoothed_mg);
			r.baseline_norm_mg = 13'(rest_norm_mg);
			r.norm_deviation_mg = 13'(dev);
			r.rotation_energy = 14'(energy);
			r.activity_score = 13'(score);
			if (!calibrated) begin
				r.quality_grade = imq_pkg::GradeUncal;
			end else if (pending) begin
				r.quality_grade = imq_pkg::GradePending;
			end else if (!still && dev > 240) begin
				r.quality_grade = imq_pkg::GradeMoving;
			end else if (dev > 320) begin
				r.quality_grade = imq_pkg::GradeDrift;
			end else if (score < 25) begin
				r.quality_grade = imq_pkg::GradeQuiet;
			end else begin
				r.quality_grade = imq_pkg::GradeBest;
			end
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				$display("%0t: %s expected %0d (0x%0h) got %0d (0x%0h)", $time, name,
					want, want, got, got);
			end
		endfunction

		function void check_result(conditioned_t got);
			conditioned_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result beat, expected none got 0x%0h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("accel_z_corrected", want.accel_z_corrected, got.accel_z_corrected);
			compare_field("rate_x_corrected", want.rate_x_corrected, got.rate_x_corrected);
			compare_field("rate_y_corrected", want.rate_y_corrected, got.rate_y_corrected);
			compare_field("rate_z_corrected", want.rate_z_corrected, got.rate_z_corrected);
			compare_field("still_flag", want.still_flag, got.still_flag);
			compare_field("smoothed_norm_mg", want.smoothed_norm_mg, got.smoothed_norm_mg);
			compare_field("baseline_norm_mg", want.baseline_norm_mg, got.baseline_norm_mg);
			compare_field("norm_deviation_mg", want.norm_deviation_mg, got.norm_deviation_mg);
			compare_field("rotation_energy", want.rotation_energy, got.rotation_energy);
			compare_field("activity_score", want.activity_score, got.activity_score);
			compare_field("quality_grade", want.quality_grade, got.quality_grade);
			compare_field("pad", want.pad, got.pad);
		endfunction

		function int unsigned outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [imq_pkg::InDataW-1:0]  s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [imq_pkg::OutDataW-1:0] m_tdata;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [imq_pkg::AddrW-1:0]    paddr;
	logic [imq_pkg::ApbDataW-1:0] pwdata;
	logic [imq_pkg::ApbDataW-1:0] prdata;
	logic                         pready;

	quality_scoreboard sb = new();
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	bit          hold_request;
	int unsigned hold_left;
	int unsigned cycle_count;

	imu_motion_quality_conditioner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sb.note_sample(sample_t'(s_tdata));
		end
		if (m_tvalid && m_tready) begin
			sb.check_result(conditioned_t'(m_tdata));
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = HoldCycles;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	function automatic sample_t make_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
		logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		sample_t s;
		s.accel_x = ax;
		s.accel_y = ay;
		s.accel_z = az;
		s.rate_x = gx;
		s.rate_y = gy;
		s.rate_z = gz;
		return s;
	endfunction

	function automatic logic [15:0] around(int unsigned span);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic logic [15:0] signed_mag(int unsigned m);
		return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
	endfunction

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'h0001;
		endcase
	endfunction

	// about 1 g split over the axes with random signs, small rates
	function automatic sample_t rest_sample(int unsigned rate_span);
		int unsigned total, za, xa, ya;
		total = 16084 + $urandom_range(0, 600);
		za = $urandom_range(total / 2, total);
		xa = $urandom_range(0, total - za);
		ya = total - za - xa;
		return make_sample(signed_mag(xa), signed_mag(ya), signed_mag(za),
			around(rate_span), around(rate_span), around(rate_span));
	endfunction

	task automatic send(sample_t s);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= s;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait for every pending result
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] value, int unsigned width);
		logic [31:0] keep;
		keep = (32'd1 << width) - 1;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// junk above the register width must be dropped
		pwdata <= (value & keep) | ($urandom() & ~keep);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.configure(idx, pwdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_regs(logic [14:0] thr, logic [14:0] margin, logic [15:0] bz,
		logic [15:0] bx, logic [15:0] by, logic [15:0] bgz, logic cal, logic pend);
		reg_write(imq_pkg::RegGyroThr, 32'(thr), 15);
		reg_write(imq_pkg::RegNormMargin, 32'(margin), 15);
		reg_write(imq_pkg::RegAccelZBias, 32'(bz), 16);
		reg_write(imq_pkg::RegGyroXBias, 32'(bx), 16);
		reg_write(imq_pkg::RegGyroYBias, 32'(by), 16);
		reg_write(imq_pkg::RegGyroZBias, 32'(bgz), 16);
		reg_write(imq_pkg::RegCalibrated, 32'(cal), 1);
		reg_write(imq_pkg::RegPending, 32'(pend), 1);
	endtask

	task automatic program_typical(logic cal, logic pend);
		set_regs(15'($urandom_range(50, 600)), 15'($urandom_range(20, 200)), around(60),
			around(60), around(60), around(60), cal, pend);
	endtask

	task automatic set_idling(int unsigned mode);
		case (mode)
			0: begin src_idle_pct = 0; sink_stall_pct = 0; end
			1: begin src_idle_pct = 45; sink_stall_pct = 0; end
			2: begin src_idle_pct = 0; sink_stall_pct = 45; end
			default: begin src_idle_pct = 16; sink_stall_pct = 16; end
		endcase
	endtask

	// mostly runs at rest, some motion bursts, a little noise
	task automatic run_random(int unsigned count);
		int unsigned left, kind, pick, span;
		sample_t s;
		left = 0;
		kind = 0;
		span = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (left == 0) begin
				pick = $urandom_range(0, 99);
				kind = pick < 65 ? 0 : (pick < 88 ? 1 : 2);
				left = kind == 0 ? $urandom_range(5, 60) :
					(kind == 1 ? $urandom_range(1, 10) : $urandom_range(1, 4));
				span = $urandom_range(0, 400);
			end
			left--;
			case (kind)
				0: s = rest_sample(span);
				1: s = make_sample(around(20000), around(20000), around(20000),
					around(4000), around(4000), around(4000));
				default: begin
					if ($urandom_range(0, 1)) begin
						s = {$urandom(), $urandom(), $urandom()};
					end else begin
						s = make_sample(corner_value(), corner_value(), corner_value(),
							corner_value(), corner_value(), corner_value());
					end
				end
			endcase
			send(s);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_request = 1'b0;
		set_idling(0);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out of reset: uncalibrated, never still, extreme samples
		send(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send(make_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send(make_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001));
		send(make_sample(16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h0001, 16'h8000));
		settle();

		// settle onto 1 g: moving grade first, then drift grade once at rest
		set_regs(15'd400, 15'd80, 16'd100, -16'sd5, 16'd7, 16'd3, 1'b1, 1'b0);
		for (int i = 0; i < 14; i++) begin
			send(make_sample(16'h0000, 16'h0000, 16'd16384, 16'd10, -16'sd10, 16'd5));
		end
		send(make_sample(16'h0000, 16'h0000, 16'd16384, 16'h8000, 16'd20, 16'd20));
		send(make_sample(16'd3000, -16'sd2000, 16'd16384, 16'd100, 16'd2000, -16'sd900));
		settle();
		reg_write(imq_pkg::RegPending, 32'd1, 1);
		send(make_sample(16'h0000, 16'h0000, 16'd16384, 16'd0, 16'd0, 16'd0));
		send(make_sample(16'h0100, 16'h0000, 16'd16000, 16'd50, 16'd0, 16'd0));
		settle();

		for (int unsigned phase = 0; phase < 8; phase++) begin
			case (phase)
				1: set_regs(15'h7fff, 15'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
					1'b1, 1'b0);
				2: set_regs(15'h0000, 15'h0000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
					1'b1, 1'b0);
				3: program_typical(1'b1, 1'b1);
				4: program_typical(1'b0, 1'($urandom_range(0, 1)));
				5: set_regs(15'($urandom_range(50, 600)), 15'($urandom_range(20, 200)),
					16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
				default: program_typical(1'b1, 1'b0);
			endcase
			set_idling(phase % 4);
			// fill the pipe against a stalled output
			if (phase == 0) begin
				hold_request = 1'b1;
			end
			run_random(220);
			settle();
		end

		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
